// File: design/pak_command_responder_crc8_core_macros.svh
`ifndef PAK_COMMAND_RESPONDER_CRC8_CORE_MACROS_SVH
`define PAK_COMMAND_RESPONDER_CRC8_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PCR8_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCR8_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pcr8_pkg.sv
`default_nettype none

package pcr8_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h85;
    localparam logic [7:0]  ADDR_MASK   = 8'hE0;
    localparam logic [15:0] FILL_LO     = 16'h8000;
    localparam logic [15:0] FILL_HI     = 16'h9000;
    localparam logic [15:0] RUMBLE_ADDR = 16'hC000;
    localparam logic [7:0]  FILL_SET    = 8'h80;
    localparam logic [7:0]  FILL_CLEAR  = 8'h00;
    localparam int          BLOCK_LEN   = 32;

    localparam logic [7:0]  CMD_READ    = 8'h02;
    localparam logic [7:0]  CMD_WRITE   = 8'h03;

    localparam logic [5:0]  IDX_FRAME      = 6'd0;
    localparam logic [5:0]  IDX_CMD        = 6'd2;
    localparam logic [5:0]  IDX_ADDR_HI    = 6'd3;
    localparam logic [5:0]  IDX_ADDR_LO    = 6'd4;
    localparam logic [5:0]  IDX_DATA_FIRST = 6'd5;
    localparam logic [5:0]  IDX_DATA_LAST  = 6'd36;
    localparam logic [5:0]  IDX_LIMIT      = 6'd38;

    localparam int          FILL_CW   = $clog2(BLOCK_LEN);
    localparam logic [FILL_CW-1:0] FILL_CNT_LAST = FILL_CW'(BLOCK_LEN - 1);

    typedef struct packed {
        logic [1:0] controller_id;
        logic [7:0] frame_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_is_crc;
        logic       rumble_valid;
        logic       rumble_on;
        logic [1:0] rumble_port;
        logic       last;
    } t_result;

    typedef enum logic {
        TASK_READ,
        TASK_WRITE
    } t_task_kind;

    typedef struct packed {
        t_task_kind kind;
        logic [7:0] data;
        logic       rumble_valid;
        logic       rumble_on;
        logic [1:0] rumble_port;
    } t_task;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_CRC
    } t_back_state;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/pak_command_responder_crc8_core.sv
// Path: a write reply after the last data byte is taken, or a read reply's first fill byte
// after address byte 4, passes queue and output register; 33 bytes in a row unstalled.
// Throughput: one frame byte per cycle if the queue is not full; the back end emits one
// reply byte per cycle if not stalled; a read reply holds the queue; input stalls if full.
// Reset: synchronous, active low; clears frame state, queue and output valid.
`default_nettype none

module pak_command_responder_crc8_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pcr8_pkg::t_item   i_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pcr8_pkg::t_result      o_result
);

    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;
    pcr8_pkg::t_task push_task;
    pcr8_pkg::t_task q_task;

    assign o_in_stall = q_full;

    pcr8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && !q_full),
        .i_item   (i_item),
        .o_push   (push),
        .o_task   (push_task)
    );

    pcr8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (push_task),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_task  (q_task)
    );

    pcr8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_task    (q_task),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// File: design/pcr8_front.sv
`default_nettype none

module pcr8_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire pcr8_pkg::t_item i_item,
    output logic                o_push,
    output pcr8_pkg::t_task     o_task
);

    logic [5:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_first, n_first;
    logic [1:0]  r_port, n_port;

    logic [5:0]  idx;
    logic [7:0]  b;
    logic [15:0] addr_full;
    logic [7:0]  crc_next;
    logic        rumble_hit;

    assign idx       = i_item.frame_start ? pcr8_pkg::IDX_FRAME : r_byte_count;
    assign b         = i_item.frame_byte;
    assign addr_full = {r_addr[15:8], b & pcr8_pkg::ADDR_MASK};
    assign crc_next  = pcr8_pkg::crc8_update(r_crc, b);
    assign rumble_hit = (r_addr == pcr8_pkg::RUMBLE_ADDR);

    always_comb begin
        n_byte_count = r_byte_count;
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_crc        = r_crc;
        n_first      = r_first;
        n_port       = r_port;
        o_push       = 1'b0;
        o_task       = '{kind: pcr8_pkg::TASK_WRITE, data: crc_next,
                         rumble_valid: rumble_hit,
                         rumble_on: rumble_hit && (r_first != 8'h00),
                         rumble_port: rumble_hit ? r_port : 2'd0};
        if (i_accept) begin
            if (i_item.frame_start) begin
                n_byte_count = pcr8_pkg::IDX_FRAME;
            end
            if (idx < pcr8_pkg::IDX_LIMIT) begin
                n_byte_count = idx + 6'd1;
                case (idx)
                    pcr8_pkg::IDX_FRAME: begin
                        n_port  = i_item.controller_id;
                        n_crc   = 8'h00;
                        n_first = 8'h00;
                    end
                    pcr8_pkg::IDX_CMD: begin
                        n_cmd = b;
                    end
                    pcr8_pkg::IDX_ADDR_HI: begin
                        n_addr = {b, 8'h00};
                    end
                    pcr8_pkg::IDX_ADDR_LO: begin
                        n_addr = addr_full;
                        if (r_cmd == pcr8_pkg::CMD_READ) begin
                            o_push = 1'b1;
                            o_task = '{kind: pcr8_pkg::TASK_READ,
                                       data: (addr_full inside {[pcr8_pkg::FILL_LO:
                                              pcr8_pkg::FILL_HI - 16'd1]}) ?
                                             pcr8_pkg::FILL_SET : pcr8_pkg::FILL_CLEAR,
                                       rumble_valid: 1'b0, rumble_on: 1'b0,
                                       rumble_port: 2'd0};
                        end
                    end
                    default: begin
                        if ((idx inside {[pcr8_pkg::IDX_DATA_FIRST:pcr8_pkg::IDX_DATA_LAST]}) &&
                            r_cmd == pcr8_pkg::CMD_WRITE) begin
                            if (idx == pcr8_pkg::IDX_DATA_FIRST) begin
                                n_first = b;
                            end
                            n_crc = crc_next;
                            if (idx == pcr8_pkg::IDX_DATA_LAST) begin
                                o_push = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_cmd        <= '0;
            r_addr       <= '0;
            r_crc        <= '0;
            r_first      <= '0;
            r_port       <= '0;
        end else begin
            r_byte_count <= n_byte_count;
            r_cmd        <= n_cmd;
            r_addr       <= n_addr;
            r_crc        <= n_crc;
            r_first      <= n_first;
            r_port       <= n_port;
        end
    end

endmodule

`default_nettype wire

// File: design/pcr8_queue.sv
`default_nettype none

module pcr8_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pcr8_pkg::t_task i_task,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output pcr8_pkg::t_task      o_task
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pcr8_pkg::t_task r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_task  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: design/pcr8_back.sv
`default_nettype none

module pcr8_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire pcr8_pkg::t_task i_q_task,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output pcr8_pkg::t_result    o_result
);

    pcr8_pkg::t_back_state r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    pcr8_pkg::t_result     r_out, n_out;
    logic [pcr8_pkg::FILL_CW-1:0] r_cnt, n_cnt;
    logic [7:0]            r_crc, n_crc;
    logic [7:0]            r_fill, n_fill;
    logic                  load_ok;

    assign load_ok     = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcr8_pkg::BK_IDLE: begin
                if (load_ok && i_q_valid && i_q_task.kind == pcr8_pkg::TASK_READ) begin
                    n_state = pcr8_pkg::BK_FILL;
                end
            end
            pcr8_pkg::BK_FILL: begin
                if (load_ok && r_cnt == pcr8_pkg::FILL_CNT_LAST) begin
                    n_state = pcr8_pkg::BK_CRC;
                end
            end
            pcr8_pkg::BK_CRC: begin
                if (load_ok) begin
                    n_state = pcr8_pkg::BK_IDLE;
                end
            end
            default: n_state = pcr8_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_fill      = r_fill;
        o_pop       = 1'b0;
        case (r_state)
            pcr8_pkg::BK_IDLE: begin
                if (load_ok && i_q_valid) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_q_task.kind == pcr8_pkg::TASK_READ) begin
                        n_out  = '{reply_byte: i_q_task.data, reply_is_crc: 1'b0,
                                   rumble_valid: 1'b0, rumble_on: 1'b0,
                                   rumble_port: 2'd0, last: 1'b0};
                        n_fill = i_q_task.data;
                        n_crc  = pcr8_pkg::crc8_update(8'h00, i_q_task.data);
                        n_cnt  = pcr8_pkg::FILL_CW'(1);
                    end else begin
                        n_out = '{reply_byte: i_q_task.data, reply_is_crc: 1'b1,
                                  rumble_valid: i_q_task.rumble_valid,
                                  rumble_on: i_q_task.rumble_on,
                                  rumble_port: i_q_task.rumble_port, last: 1'b1};
                    end
                end
            end
            pcr8_pkg::BK_FILL: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out = '{reply_byte: r_fill, reply_is_crc: 1'b0,
                              rumble_valid: 1'b0, rumble_on: 1'b0,
                              rumble_port: 2'd0, last: 1'b0};
                    n_crc = pcr8_pkg::crc8_update(r_crc, r_fill);
                    n_cnt = r_cnt + 1'b1;
                end
            end
            pcr8_pkg::BK_CRC: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out = '{reply_byte: r_crc, reply_is_crc: 1'b1,
                              rumble_valid: 1'b0, rumble_on: 1'b0,
                              rumble_port: 2'd0, last: 1'b1};
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_cnt  <= n_cnt;
        r_crc  <= n_crc;
        r_fill <= n_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcr8_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: design/pcr8_checker.sv
`default_nettype none
`include "pak_command_responder_crc8_core_macros.svh"

module pcr8_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire pcr8_pkg::t_result o_result
);

    logic held;
    logic rumble_ev;
    logic no_rumble;
    logic rumble_clear;

    assign held         = o_out_valid && i_out_stall;
    assign rumble_ev    = o_out_valid && o_result.rumble_valid;
    assign no_rumble    = o_out_valid && !o_result.rumble_valid;
    assign rumble_clear = !o_result.rumble_on && (o_result.rumble_port == 2'd0);

    `PCR8_ASSERT_NEXT(a_out_hold, held, o_out_valid && $stable(o_result), "stalled reply changed")
    `PCR8_ASSERT(a_last_crc, o_out_valid, o_result.last == o_result.reply_is_crc, "last flag off")
    `PCR8_ASSERT(a_rumble_crc, rumble_ev, o_result.reply_is_crc, "rumble on fill byte")
    `PCR8_ASSERT(a_rumble_on, no_rumble, rumble_clear, "rumble fields set without event")

endmodule

bind pak_command_responder_crc8_core pcr8_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);

`default_nettype wire

// File: dv/tb_pak_command_responder_crc8_core.sv
module tb_pak_command_responder_crc8_core;
    import pcr8_pkg::*;

    localparam int        ITEM_TARGET   = 260;
    localparam int        REPORT_LIMIT  = 10;
    localparam int        DRAIN_CYCLES  = 12;
    localparam logic [7:0] CMD_STATUS   = 8'h00;
    localparam logic [7:0] CMD_RESET    = 8'hFF;

    typedef logic [7:0] frame_q_t[$];
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    class pak_reply_scoreboard;
        t_result    reply_fifo[$];
        logic [5:0] frame_pos = '0;
        logic [7:0] cmd_code  = '0;
        logic [15:0] pak_addr = '0;
        logic [7:0] wr_crc    = '0;
        logic [7:0] wr_first  = '0;
        logic [1:0] port      = '0;
        int errors   = 0;
        int checked  = 0;
        int items    = 0;
        int reads    = 0;
        int writes   = 0;
        int rumbles  = 0;

        function logic [7:0] crc85_byte(logic [7:0] crc, logic [7:0] data);
            logic [7:0] r;
            r = crc;
            for (int i = 7; i >= 0; i--) begin
                if (r[7] ^ data[i]) begin
                    r = {r[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    r = {r[6:0], 1'b0};
                end
            end
            return r;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("ERROR: %s", msg);
            end
        endfunction

        function void note_item(t_item it);
            logic [7:0] fill;
            logic [7:0] rd_crc;
            t_result r;
            if (it.frame_start) begin
                frame_pos = IDX_FRAME;
            end
            if (frame_pos >= IDX_LIMIT) begin
                return;
            end
            items++;
            case (frame_pos)
                IDX_FRAME: begin
                    port     = it.controller_id;
                    wr_crc   = '0;
                    wr_first = '0;
                end
                IDX_CMD: cmd_code = it.frame_byte;
                IDX_ADDR_HI: pak_addr = {it.frame_byte, 8'h00};
                IDX_ADDR_LO: begin
                    pak_addr[7:0] = it.frame_byte & ADDR_MASK;
                    if (cmd_code == CMD_READ) begin
                        fill = (pak_addr >= FILL_LO && pak_addr < FILL_HI) ? FILL_SET
                                                                          : FILL_CLEAR;
                        rd_crc = '0;
                        for (int i = 0; i < BLOCK_LEN; i++) begin
                            r = '0;
                            r.reply_byte = fill;
                            reply_fifo.push_back(r);
                            rd_crc = crc85_byte(rd_crc, fill);
                        end
                        r = '0;
                        r.reply_byte   = rd_crc;
                        r.reply_is_crc = 1'b1;
                        r.last         = 1'b1;
                        reply_fifo.push_back(r);
                        reads++;
                    end
                end
                default: begin
                    if (cmd_code == CMD_WRITE && frame_pos >= IDX_DATA_FIRST &&
                        frame_pos <= IDX_DATA_LAST) begin
                        if (frame_pos == IDX_DATA_FIRST) begin
                            wr_first = it.frame_byte;
                        end
                        wr_crc = crc85_byte(wr_crc, it.frame_byte);
                        if (frame_pos == IDX_DATA_LAST) begin
                            r = '0;
                            r.reply_byte   = wr_crc;
                            r.reply_is_crc = 1'b1;
                            r.rumble_valid = (pak_addr == RUMBLE_ADDR);
                            r.rumble_on    = r.rumble_valid && (wr_first != 8'h00);
                            r.rumble_port  = r.rumble_valid ? port : 2'd0;
                            r.last         = 1'b1;
                            reply_fifo.push_back(r);
                            writes++;
                            if (r.rumble_valid) begin
                                rumbles++;
                            end
                        end
                    end
                end
            endcase
            frame_pos++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (reply_fifo.size() == 0) begin
                report($sformatf("unexpected reply byte=%02h crc=%b rv=%b ro=%b rp=%0d last=%b",
                                 got.reply_byte, got.reply_is_crc, got.rumble_valid,
                                 got.rumble_on, got.rumble_port, got.last));
                return;
            end
            want = reply_fifo.pop_front();
            checked++;
            if (got.reply_byte !== want.reply_byte || got.reply_is_crc !== want.reply_is_crc ||
                got.rumble_valid !== want.rumble_valid || got.rumble_on !== want.rumble_on ||
                got.rumble_port !== want.rumble_port || got.last !== want.last) begin
                report($sformatf({"reply %0d: expected byte=%02h crc=%b rv=%b ro=%b rp=%0d ",
                                  "last=%b, got byte=%02h crc=%b rv=%b ro=%b rp=%0d last=%b"},
                                 checked, want.reply_byte, want.reply_is_crc,
                                 want.rumble_valid, want.rumble_on, want.rumble_port,
                                 want.last, got.reply_byte, got.reply_is_crc,
                                 got.rumble_valid, got.rumble_on, got.rumble_port, got.last));
            end
        endfunction

        function void finish_check();
            if (reply_fifo.size() != 0) begin
                report($sformatf("%0d expected reply bytes never arrived", reply_fifo.size()));
            end
        endfunction
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    logic    i_out_stall = 1'b0;
    t_item   i_item      = '0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_result;

    pak_reply_scoreboard sb = new();
    int       burst_left = 0;
    int       rx_cycle   = 0;
    rx_mode_e rx_mode    = RX_OPEN;

    pak_command_responder_crc8_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_result);
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 256 == 255) begin
                rx_mode <= rx_mode_e'($urandom_range(0, 2));
            end
            case (rx_mode)
                RX_OPEN:    i_out_stall <= 1'b0;
                RX_RANDOM:  i_out_stall <= ($urandom_range(0, 3) == 0);
                default:    i_out_stall <= (rx_cycle % 8 < 5);
            endcase
        end
    end

    task automatic send_item(input t_item it);
        int idle;
        if (burst_left == 0) begin
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0) begin
                i_in_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_item     <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic send_frame(input logic [1:0] port, input frame_q_t bytes,
                              input bit with_start);
        t_item it;
        foreach (bytes[i]) begin
            it.controller_id = (i == 0) ? port : 2'($urandom_range(0, 3));
            it.frame_byte    = bytes[i];
            it.frame_start   = (i == 0) && with_start;
            send_item(it);
        end
    endtask

    function automatic frame_q_t make_frame(input logic [7:0] cmd, input logic [15:0] addr,
                                            input int n_data, input bit first_zero);
        frame_q_t q;
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(cmd);
        q.push_back(addr[15:8]);
        q.push_back(addr[7:0]);
        for (int i = 0; i < n_data; i++) begin
            q.push_back((i == 0 && first_zero) ? 8'h00 : 8'($urandom));
        end
        return q;
    endfunction

    function automatic logic [15:0] pick_addr(input bit is_write);
        case ($urandom_range(0, 5))
            0:       return RUMBLE_ADDR | 16'($urandom_range(0, 31));
            1:       return is_write ? RUMBLE_ADDR : FILL_LO | 16'($urandom_range(0, 4095));
            2:       return FILL_HI | 16'($urandom_range(0, 31));
            3:       return (FILL_LO - 16'd32) | 16'($urandom_range(0, 31));
            4:       return FILL_LO | 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        frame_q_t fr;
        t_item    it;
        int       kind;
        int       n;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first byte after reset counts as byte 0; top of the 0x80 fill window
        send_frame(2'd3, make_frame(CMD_READ, 16'h8FFF, 0, 1'b0), 1'b0);
        // just past the fill window, then bytes that only advance the count
        send_frame(2'd0, make_frame(CMD_READ, FILL_HI, 2, 1'b0), 1'b1);
        send_frame(2'd1, make_frame(CMD_READ, 16'h7FFF, 0, 1'b0), 1'b1);
        send_frame(2'd2, make_frame(CMD_RESET, 16'hFFFF, 1, 1'b0), 1'b1);
        // rumble write with masked low address bits, first data byte 0x01, overlong
        fr = make_frame(CMD_WRITE, 16'hC01F, BLOCK_LEN + 3, 1'b0);
        fr[5] = 8'h01;
        send_frame(2'd2, fr, 1'b1);

        while (sb.items < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
                send_frame(2'($urandom), make_frame(CMD_READ, pick_addr(1'b0), n, 1'b0),
                           1'b1);
            end else if (kind < 75) begin
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(0, BLOCK_LEN - 1);
                    1:       n = BLOCK_LEN + $urandom_range(1, 4);
                    default: n = BLOCK_LEN;
                endcase
                send_frame(2'($urandom), make_frame(CMD_WRITE, pick_addr(1'b1), n,
                                                    $urandom_range(0, 2) == 0), 1'b1);
            end else if (kind < 85) begin
                send_frame(2'($urandom),
                           make_frame($urandom_range(0, 1) ? CMD_STATUS : 8'($urandom),
                                      16'($urandom), $urandom_range(0, 8), 1'b0),
                           $urandom_range(0, 3) != 0);
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    it.controller_id = 2'($urandom);
                    it.frame_byte    = 8'($urandom);
                    it.frame_start   = ($urandom_range(0, 3) == 0);
                    send_item(it);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (sb.reply_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.finish_check();

        $display("Sent %0d counted frame bytes: %0d pak reads, %0d pak writes (%0d rumble).",
                 sb.items, sb.reads, sb.writes, sb.rumbles);
        $display("Checked %0d reply bytes, %0d errors.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("ERROR: timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
